@@ rtl/core/dpl_pkg.sv @@
// Package for the demand paging translator with local page replacement.
// Holds sizes, status codes, sequencer states and the item structs.
// No dependencies.
`timescale 1ns / 1ps
package dpl_pkg;
  localparam int NUM_PROCS      = 8;
  localparam int PAGES_PER_PROC = 64;
  localparam int FRAME_COUNT    = 64;
  localparam int PAGE_BYTES     = 64;
  localparam int ENTRY_COUNT    = NUM_PROCS * PAGES_PER_PROC;
  localparam int PID_W          = 3;
  localparam int PAGE_W         = 6;
  localparam int OFF_W          = 6;
  localparam int CNT_W          = 7;
  localparam int FRAME_W        = 6;
  localparam int STAMP_W        = 32;
  localparam int ENTRY_AW       = PID_W + PAGE_W;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_FAULT     = 3'd1;
  localparam logic [2:0] ST_EVICT     = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_NO_VICTIM = 3'd4;

  localparam logic REG_RESIDENT_LIMIT = 1'b0;
  localparam logic REG_REPLACE_MODE   = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_EVAL, S_SCAN, S_FIN, S_WRITE
  } state_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  process_pages;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [FRAME_W-1:0] frame;
    logic [OFF_W-1:0]   phys_offset;
    logic [CNT_W-1:0]   resident_count;
  } result_t;

  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
    logic [STAMP_W-1:0] last_use;
    logic [STAMP_W-1:0] load;
  } entry_t;
endpackage

@@ rtl/core/dpl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/dpl_victim.sv @@
// Shared stamp comparator: keeps the lowest page with the smallest stamp.
// Depends on dpl_pkg.
`timescale 1ns / 1ps
module dpl_victim (
  input  logic                         clk,
  input  logic                         clear,
  input  logic                         vld,
  input  logic                         present,
  input  logic [dpl_pkg::STAMP_W-1:0]  stamp,
  input  logic [dpl_pkg::PAGE_W-1:0]   idx,
  input  logic [dpl_pkg::FRAME_W-1:0]  frame,
  output logic                         found,
  output logic [dpl_pkg::PAGE_W-1:0]   best_idx,
  output logic [dpl_pkg::FRAME_W-1:0]  best_frame
);
  logic [dpl_pkg::STAMP_W-1:0] best_stamp;
  logic                        take;

  assign take = vld && present && (!found || (stamp < best_stamp));

  always_ff @(posedge clk) begin
    if (clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
    if (take) begin
      best_stamp <= stamp;
      best_idx   <= idx;
      best_frame <= frame;
    end
  end
endmodule

@@ rtl/core/demand_paging_with_local_replacement_unit.sv @@
// Top level: demand paging translator with per-process page replacement.
// Invalid items end in S_CHECK, hits and free-frame faults in S_EVAL; else S_SCAN runs a
// 64-entry victim scan through the RAM's one read port, then S_FIN reports no victim or
// S_WRITE maps its frame. One item at a time: the next is taken at the edge that takes the
// result. Reset: synchronous; a clearing pass marks all pages absent, busy high meanwhile.
// Results are strobed by done for one cycle and cannot be stalled.
`timescale 1ns / 1ps
module demand_paging_with_local_replacement_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dpl_pkg::item_t   item,
  output logic             done,
  output dpl_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [6:0]       cfg_data
);
  dpl_pkg::state_t state, state_next;
  dpl_pkg::item_t  cur;
  dpl_pkg::entry_t rd_entry, wr_entry;

  logic [dpl_pkg::CNT_W-1:0]    resident_limit;
  logic                         replace_mode;
  logic [dpl_pkg::CNT_W-1:0]    res [dpl_pkg::NUM_PROCS];
  logic [dpl_pkg::CNT_W-1:0]    frames_in_use;
  logic [dpl_pkg::STAMP_W-1:0]  lclock;
  logic [dpl_pkg::ENTRY_AW-1:0] clr_cnt;
  logic [dpl_pkg::PAGE_W:0]     ic;
  logic                         scan_vld;
  logic [dpl_pkg::PAGE_W-1:0]   scan_idx;
  logic                         we;
  logic [dpl_pkg::ENTRY_AW-1:0] waddr, raddr, e_addr;
  logic                         found;
  logic [dpl_pkg::PAGE_W-1:0]   best_idx;
  logic [dpl_pkg::FRAME_W-1:0]  best_frame;
  logic [dpl_pkg::CNT_W-1:0]    cur_res;
  logic                         invalid, need_evict;

  assign e_addr     = {cur.pid, cur.page};
  assign cur_res    = res[cur.pid];
  assign invalid    = {1'b0, cur.page} >= cur.process_pages;
  assign need_evict = (cur_res >= resident_limit)
                   || (frames_in_use >= dpl_pkg::CNT_W'(dpl_pkg::FRAME_COUNT));
  assign busy       = state != dpl_pkg::S_IDLE;

  dpl_ram #(.WIDTH($bits(dpl_pkg::entry_t)), .DEPTH(dpl_pkg::ENTRY_COUNT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_entry), .raddr(raddr), .rdata(rd_entry)
  );

  dpl_victim u_victim (
    .clk(clk), .clear(state == dpl_pkg::S_EVAL), .vld(scan_vld),
    .present(rd_entry.present),
    .stamp(replace_mode ? rd_entry.load : rd_entry.last_use),
    .idx(scan_idx), .frame(rd_entry.frame),
    .found(found), .best_idx(best_idx), .best_frame(best_frame)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      dpl_pkg::S_CLEAR: if (&clr_cnt) state_next = dpl_pkg::S_IDLE;
      dpl_pkg::S_IDLE:  if (start) state_next = dpl_pkg::S_CHECK;
      dpl_pkg::S_CHECK: state_next = invalid ? dpl_pkg::S_IDLE : dpl_pkg::S_EVAL;
      dpl_pkg::S_EVAL: begin
        if (!rd_entry.present && need_evict) state_next = dpl_pkg::S_SCAN;
        else state_next = dpl_pkg::S_IDLE;
      end
      dpl_pkg::S_SCAN:  if (ic[dpl_pkg::PAGE_W]) state_next = dpl_pkg::S_FIN;
      dpl_pkg::S_FIN:   state_next = found ? dpl_pkg::S_WRITE : dpl_pkg::S_IDLE;
      dpl_pkg::S_WRITE: state_next = dpl_pkg::S_IDLE;
      default:          state_next = dpl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    we       = 1'b0;
    waddr    = e_addr;
    wr_entry = '0;
    raddr    = e_addr;
    unique case (state)
      dpl_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      dpl_pkg::S_EVAL: begin
        we                = !(!rd_entry.present && need_evict);
        wr_entry.present  = 1'b1;
        wr_entry.last_use = lclock;
        if (rd_entry.present) begin
          wr_entry.frame = rd_entry.frame;
          wr_entry.load  = rd_entry.load;
        end else begin
          wr_entry.frame = frames_in_use[dpl_pkg::FRAME_W-1:0];
          wr_entry.load  = lclock;
        end
      end
      dpl_pkg::S_SCAN:  raddr = {cur.pid, ic[dpl_pkg::PAGE_W-1:0]};
      dpl_pkg::S_FIN: begin
        we    = found;
        waddr = {cur.pid, best_idx};
      end
      dpl_pkg::S_WRITE: begin
        we                = 1'b1;
        wr_entry.present  = 1'b1;
        wr_entry.frame    = best_frame;
        wr_entry.last_use = lclock;
        wr_entry.load     = lclock;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= dpl_pkg::S_CLEAR;
      clr_cnt        <= '0;
      resident_limit <= 7'd8;
      replace_mode   <= 1'b0;
      frames_in_use  <= '0;
      lclock         <= '0;
      done           <= 1'b0;
      scan_vld       <= 1'b0;
      ic             <= '0;
      for (int i = 0; i < dpl_pkg::NUM_PROCS; i++) res[i] <= '0;
    end else begin
      state    <= state_next;
      done     <= 1'b0;
      scan_vld <= (state == dpl_pkg::S_SCAN) && !ic[dpl_pkg::PAGE_W];
      scan_idx <= ic[dpl_pkg::PAGE_W-1:0];
      if (cfg_we) begin
        if (cfg_index == dpl_pkg::REG_RESIDENT_LIMIT) resident_limit <= cfg_data;
        else replace_mode <= cfg_data[0];
      end
      unique case (state)
        dpl_pkg::S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        dpl_pkg::S_IDLE:  if (start) cur <= item;
        dpl_pkg::S_CHECK: begin
          if (invalid) begin
            done   <= 1'b1;
            result <= '{dpl_pkg::ST_INVALID, '0, '0, cur_res};
          end
        end
        dpl_pkg::S_EVAL: begin
          ic <= '0;
          if (rd_entry.present) begin
            lclock <= lclock + 1'b1;
            done   <= 1'b1;
            result <= '{dpl_pkg::ST_HIT, rd_entry.frame, cur.offset, cur_res};
          end else if (!need_evict) begin
            lclock        <= lclock + 1'b1;
            frames_in_use <= frames_in_use + 1'b1;
            res[cur.pid]  <= cur_res + 1'b1;
            done          <= 1'b1;
            result <= '{dpl_pkg::ST_FAULT, frames_in_use[dpl_pkg::FRAME_W-1:0],
                        cur.offset, cur_res + 1'b1};
          end
        end
        dpl_pkg::S_SCAN: if (!ic[dpl_pkg::PAGE_W]) ic <= ic + 1'b1;
        dpl_pkg::S_FIN: begin
          if (!found) begin
            done   <= 1'b1;
            result <= '{dpl_pkg::ST_NO_VICTIM, '0, '0, cur_res};
          end
        end
        dpl_pkg::S_WRITE: begin
          lclock <= lclock + 1'b1;
          done   <= 1'b1;
          result <= '{dpl_pkg::ST_EVICT, best_frame, cur.offset, cur_res};
        end
        default: ;
      endcase
    end
  end
endmodule

@@ tb/sv/demand_paging_with_local_replacement_unit_test.sv @@
// Testbench for the demand paging translator with per-process page replacement.
// Drives a directed table, then random accesses; checks typed rows against the table
// and others against a testbench page table tracker. Depends on dpl_pkg and the unit.
`timescale 1ns / 1ps
module demand_paging_with_local_replacement_unit_test;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  dpl_pkg::item_t item = '0;
  logic done;
  dpl_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic cfg_index = dpl_pkg::REG_RESIDENT_LIMIT;
  logic [6:0] cfg_data = '0;

  demand_paging_with_local_replacement_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracked page tables
  logic                        pt_present [dpl_pkg::ENTRY_COUNT];
  logic [dpl_pkg::FRAME_W-1:0] pt_frame [dpl_pkg::ENTRY_COUNT];
  logic [dpl_pkg::STAMP_W-1:0] pt_last_use [dpl_pkg::ENTRY_COUNT];
  logic [dpl_pkg::STAMP_W-1:0] pt_load [dpl_pkg::ENTRY_COUNT];
  logic [dpl_pkg::CNT_W-1:0]   held_frames [dpl_pkg::NUM_PROCS];
  logic [dpl_pkg::CNT_W-1:0]   pool_used;
  logic [dpl_pkg::STAMP_W-1:0] access_clock;
  logic [6:0]                  limit_setting;
  logic                        fifo_mode;

  dpl_pkg::result_t pending_translations [$];
  int errors = 0;
  int idle_cycles = 0;

  typedef struct {
    dpl_pkg::item_t   acc;
    bit               typed;
    dpl_pkg::result_t want;
  } access_row_t;

  function automatic dpl_pkg::result_t translate_access(dpl_pkg::item_t a);
    dpl_pkg::result_t r;
    int e, victim;
    logic [dpl_pkg::STAMP_W-1:0] best, s;
    logic [dpl_pkg::FRAME_W-1:0] fr;
    r = '0;
    if (a.page >= a.process_pages || a.page >= dpl_pkg::PAGES_PER_PROC) begin
      r.status = dpl_pkg::ST_INVALID;
      r.resident_count = held_frames[a.pid];
      return r;
    end
    e = a.pid * dpl_pkg::PAGES_PER_PROC + a.page;
    if (pt_present[e]) begin
      r.status = dpl_pkg::ST_HIT;
    end else begin
      if (held_frames[a.pid] >= limit_setting || pool_used >= dpl_pkg::FRAME_COUNT) begin
        victim = -1;
        best = '0;
        for (int p = 0; p < dpl_pkg::PAGES_PER_PROC; p++) begin
          if (pt_present[a.pid * dpl_pkg::PAGES_PER_PROC + p]) begin
            s = fifo_mode ? pt_load[a.pid * dpl_pkg::PAGES_PER_PROC + p]
                          : pt_last_use[a.pid * dpl_pkg::PAGES_PER_PROC + p];
            if (victim < 0 || s < best) begin
              victim = p;
              best = s;
            end
          end
        end
        if (victim < 0) begin
          r.status = dpl_pkg::ST_NO_VICTIM;
          r.resident_count = held_frames[a.pid];
          return r;
        end
        pt_present[a.pid * dpl_pkg::PAGES_PER_PROC + victim] = 1'b0;
        fr = pt_frame[a.pid * dpl_pkg::PAGES_PER_PROC + victim];
        r.status = dpl_pkg::ST_EVICT;
      end else begin
        fr = pool_used[dpl_pkg::FRAME_W-1:0];
        pool_used++;
        held_frames[a.pid]++;
        r.status = dpl_pkg::ST_FAULT;
      end
      pt_frame[e] = fr;
      pt_present[e] = 1'b1;
      pt_load[e] = access_clock;
    end
    pt_last_use[e] = access_clock;
    access_clock++;
    r.frame = pt_frame[e];
    r.phys_offset = a.offset;
    r.resident_count = held_frames[a.pid];
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    dpl_pkg::result_t want;
    if (!rst && done) begin
      if (pending_translations.size() == 0) begin
        flag_mismatch("unexpected result, status", int'(result.status), -1);
      end else begin
        want = pending_translations.pop_front();
        if (result.status !== want.status)
          flag_mismatch("status", int'(result.status), int'(want.status));
        if (result.frame !== want.frame)
          flag_mismatch("frame", int'(result.frame), int'(want.frame));
        if (result.phys_offset !== want.phys_offset)
          flag_mismatch("phys_offset", int'(result.phys_offset), int'(want.phys_offset));
        if (result.resident_count !== want.resident_count)
          flag_mismatch("resident_count", int'(result.resident_count),
                        int'(want.resident_count));
      end
    end
  end

  always @(posedge clk) begin
    if (done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // keeps start high across back-to-back items unless a random gap drops it first
  task automatic send_access(dpl_pkg::item_t a, bit typed, dpl_pkg::result_t want);
    int gap;
    dpl_pkg::result_t got;
    gap = int'($urandom_range(0, 8));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= a;
    do @(posedge clk); while (busy);
    got = translate_access(a);
    if (typed) got = want;
    pending_translations.insert(pending_translations.size(), got);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dpl_pkg::REG_RESIDENT_LIMIT) limit_setting = val;
    else fifo_mode = val[0];
  endtask

  function automatic dpl_pkg::item_t mk(int pid, int pg, int off, int np);
    dpl_pkg::item_t a;
    a.pid = 3'(pid);
    a.page = 6'(pg);
    a.offset = 6'(off);
    a.process_pages = 7'(np);
    return a;
  endfunction

  function automatic dpl_pkg::result_t res(logic [2:0] st, int fr, int off, int cnt);
    dpl_pkg::result_t r;
    r.status = st;
    r.frame = 6'(fr);
    r.phys_offset = 6'(off);
    r.resident_count = 7'(cnt);
    return r;
  endfunction

  function automatic access_row_t mk_row(dpl_pkg::item_t acc, bit typed,
                                         dpl_pkg::result_t want);
    access_row_t row;
    row.acc = acc;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  initial begin
    access_row_t rows [$];
    dpl_pkg::item_t a;
    int limits [5] = '{64, 1, 8, 3, 2};
    for (int i = 0; i < dpl_pkg::ENTRY_COUNT; i++) pt_present[i] = 1'b0;
    for (int i = 0; i < dpl_pkg::NUM_PROCS; i++) held_frames[i] = '0;
    pool_used = '0;
    access_clock = '0;
    limit_setting = 7'd8;
    fifo_mode = 1'b0;

    rows.insert(rows.size(), mk_row(mk(0, 0, 63, 64), 1'b1, res(dpl_pkg::ST_FAULT, 0, 63, 1)));
    rows.insert(rows.size(), mk_row(mk(0, 63, 0, 64), 1'b1, res(dpl_pkg::ST_FAULT, 1, 0, 2)));
    rows.insert(rows.size(), mk_row(mk(0, 0, 21, 64), 1'b1, res(dpl_pkg::ST_HIT, 0, 21, 2)));
    rows.insert(rows.size(), mk_row(mk(0, 5, 42, 5), 1'b1, res(dpl_pkg::ST_INVALID, 0, 0, 2)));
    rows.insert(rows.size(), mk_row(mk(3, 0, 7, 0), 1'b1, res(dpl_pkg::ST_INVALID, 0, 0, 0)));
    rows.insert(rows.size(), mk_row(mk(7, 63, 0, 64), 1'b1, res(dpl_pkg::ST_FAULT, 2, 0, 1)));
    rows.insert(rows.size(), mk_row(mk(7, 42, 63, 43), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk(7, 63, 1, 63), 1'b0, '0));
    for (int p = 1; p < 10; p++)
      rows.insert(rows.size(), mk_row(mk(0, p, p * 5, 64), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk(0, 63, 9, 64), 1'b0, '0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    foreach (rows[i]) send_access(rows[i].acc, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(dpl_pkg::REG_RESIDENT_LIMIT, 7'(limits[ph]));
      write_reg(dpl_pkg::REG_REPLACE_MODE, 7'(ph % 2));
      for (int n = 0; n < 170; n++) begin
        a.pid = 3'($urandom_range(0, dpl_pkg::NUM_PROCS - 1));
        a.offset = 6'($urandom_range(0, 63));
        a.page = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 11))
                                            : 6'($urandom_range(0, 63));
        a.process_pages = ($urandom_range(0, 9) < 8) ? 7'd64 : 7'($urandom_range(0, 64));
        send_access(a, 1'b0, '0);
      end
    end

    drain();
    repeat (80) @(posedge clk);
    if (errors == 0 && pending_translations.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ demand_paging_with_local_replacement_unit.f @@
rtl/core/dpl_pkg.sv
rtl/core/dpl_ram.sv
rtl/core/dpl_victim.sv
rtl/core/demand_paging_with_local_replacement_unit.sv
tb/sv/demand_paging_with_local_replacement_unit_test.sv
